// File: hw/rtl/fsfe_pkg.sv
// Shared types and character constants for the f-string field end scanner.
`timescale 1ns / 1ps
package fsfe_pkg;

	localparam logic [7:0] CHR_HASH    = 8'h23;
	localparam logic [7:0] CHR_COLON   = 8'h3A;
	localparam logic [7:0] CHR_LBRACE  = 8'h7B;
	localparam logic [7:0] CHR_RBRACE  = 8'h7D;
	localparam logic [7:0] CHR_LPAREN  = 8'h28;
	localparam logic [7:0] CHR_LBRACK  = 8'h5B;
	localparam logic [7:0] CHR_RPAREN  = 8'h29;
	localparam logic [7:0] CHR_RBRACK  = 8'h5D;
	localparam logic [7:0] CHR_SQUOTE  = 8'h27;
	localparam logic [7:0] CHR_DQUOTE  = 8'h22;
	localparam logic [7:0] CHR_BSLASH  = 8'h5C;
	localparam logic [7:0] CHR_LF      = 8'h0A;
	localparam logic [7:0] CHR_CR      = 8'h0D;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0]  ch;
		logic        first;
		logic        last;
		logic [15:0] base_index;
	} byte_item_t;

	typedef struct packed {
		logic        found;
		logic [15:0] position;
	} res_item_t;

	typedef enum logic [3:0] {
		CC_OTHER,
		CC_HASH,
		CC_SQUOTE,
		CC_DQUOTE,
		CC_OPEN,
		CC_CLOSE,
		CC_COLON,
		CC_LBRACE,
		CC_RBRACE,
		CC_BSLASH,
		CC_EOL
	} char_class_t;

	typedef struct packed {
		char_class_t cls;
		logic        first;
		logic        last;
		logic [15:0] base_index;
	} cls_item_t;

	typedef enum logic [2:0] {
		LEX_CODE,
		LEX_COMMENT,
		LEX_OPENING,
		LEX_SINGLE,
		LEX_TRIPLE
	} lex_mode_t;

endpackage

// File: hw/rtl/fsfe_front.sv
// Front end: accepts raw bytes and classifies them for the scanner.
`timescale 1ns / 1ps
module fsfe_front (
	input  logic                byte_valid,
	output logic                byte_ready,
	input  fsfe_pkg::byte_item_t byte_item,
	input  logic                q_full,
	output logic                q_push,
	output fsfe_pkg::cls_item_t q_item
);
	import fsfe_pkg::*;

	char_class_t cls;

	always_comb begin
		unique case (byte_item.ch)
			CHR_HASH:               cls = CC_HASH;
			CHR_SQUOTE:             cls = CC_SQUOTE;
			CHR_DQUOTE:             cls = CC_DQUOTE;
			CHR_LPAREN, CHR_LBRACK: cls = CC_OPEN;
			CHR_RPAREN, CHR_RBRACK: cls = CC_CLOSE;
			CHR_COLON:              cls = CC_COLON;
			CHR_LBRACE:             cls = CC_LBRACE;
			CHR_RBRACE:             cls = CC_RBRACE;
			CHR_BSLASH:             cls = CC_BSLASH;
			CHR_LF, CHR_CR:         cls = CC_EOL;
			default:                cls = CC_OTHER;
		endcase
	end

	assign byte_ready        = !q_full;
	assign q_push            = byte_valid && !q_full;
	assign q_item.cls        = cls;
	assign q_item.first      = byte_item.first;
	assign q_item.last       = byte_item.last;
	assign q_item.base_index = byte_item.base_index;

endmodule

// File: hw/rtl/fsfe_queue.sv
// Small FIFO of classified bytes between the front end and the scanner.
`timescale 1ns / 1ps
module fsfe_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fsfe_pkg::cls_item_t push_item,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output fsfe_pkg::cls_item_t head_item
);
	import fsfe_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cls_item_t         mem_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full       = count_q == CW'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: hw/rtl/fsfe_back.sv
// Back end: brace, group and lexical mode tracking plus the result register.
`timescale 1ns / 1ps
module fsfe_back #(
	parameter int MAX_NEST   = 31,
	parameter int INDEX_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  fsfe_pkg::cls_item_t head_item,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_ready,
	output fsfe_pkg::res_item_t res_item
);
	import fsfe_pkg::*;

	localparam int BW = $clog2(MAX_NEST + 1);
	localparam int GW = BW + 1;
	localparam logic [BW-1:0]        BMAX = BW'(MAX_NEST);
	localparam logic signed [GW-1:0] GMAX = GW'(MAX_NEST);
	localparam logic signed [GW-1:0] GMIN = -GMAX;

	logic [BW-1:0]         brace_q;
	logic signed [GW-1:0]  group_q;
	logic                  spec_q;
	lex_mode_t             lex_q;
	logic                  qchar_q;
	logic [1:0]            run_q;
	logic                  esc_q;
	logic [INDEX_BITS-1:0] cursor_q;
	logic                  finished_q;
	logic                  out_valid_q;
	res_item_t             out_q;

	logic [BW-1:0]         brace_c, brace_n;
	logic signed [GW-1:0]  group_c, group_n;
	logic                  spec_c, spec_n;
	lex_mode_t             lex_c, lex_n, code_lex;
	logic                  qchar_c, qchar_n;
	logic [1:0]            run_c, run_n;
	logic                  esc_c, esc_n;
	logic [INDEX_BITS-1:0] cursor_c;
	logic                  finished_c;
	logic                  is_q, code_act, hit, emit;
	char_class_t           cls;

	assign cls        = head_item.cls;
	assign brace_c    = head_item.first ? '0 : brace_q;
	assign group_c    = head_item.first ? '0 : group_q;
	assign spec_c     = head_item.first ? 1'b0 : spec_q;
	assign lex_c      = head_item.first ? LEX_CODE : lex_q;
	assign qchar_c    = head_item.first ? 1'b0 : qchar_q;
	assign run_c      = head_item.first ? 2'd0 : run_q;
	assign esc_c      = head_item.first ? 1'b0 : esc_q;
	assign cursor_c   = head_item.first ? INDEX_BITS'(head_item.base_index) : cursor_q;
	assign finished_c = head_item.first ? 1'b0 : finished_q;

	assign is_q     = qchar_c ? (cls == CC_DQUOTE) : (cls == CC_SQUOTE);
	assign code_act = (lex_c == LEX_CODE) ||
			((lex_c == LEX_OPENING) && (run_c >= 2'd2) && !is_q);

	always_comb begin
		code_lex = LEX_CODE;
		if (!spec_c && cls == CC_HASH) begin
			code_lex = LEX_COMMENT;
		end else if (!spec_c && (cls == CC_SQUOTE || cls == CC_DQUOTE)) begin
			code_lex = LEX_OPENING;
		end
	end

	// next lexical mode
	always_comb begin
		lex_n = lex_c;
		unique case (lex_c)
			LEX_COMMENT: begin
				if (cls == CC_EOL) lex_n = LEX_CODE;
			end
			LEX_OPENING: begin
				if (run_c >= 2'd2) lex_n = is_q ? LEX_TRIPLE : code_lex;
				else if (!is_q) lex_n = LEX_SINGLE;
			end
			LEX_SINGLE: begin
				if (!esc_c && cls != CC_BSLASH && is_q) lex_n = LEX_CODE;
			end
			LEX_TRIPLE: begin
				if (!esc_c && cls != CC_BSLASH && is_q && run_c >= 2'd2) lex_n = LEX_CODE;
			end
			default: lex_n = code_lex;
		endcase
	end

	// counters, flags and hit detection
	always_comb begin
		brace_n = brace_c;
		group_n = group_c;
		spec_n  = spec_c;
		qchar_n = qchar_c;
		run_n   = run_c;
		esc_n   = esc_c;
		hit     = 1'b0;
		unique case (lex_c)
			LEX_OPENING: begin
				if (run_c >= 2'd2) begin
					run_n = 2'd0;
					if (is_q) esc_n = 1'b0;
				end else if (is_q) begin
					run_n = 2'd2;
				end else begin
					run_n = 2'd0;
					if (cls == CC_BSLASH) esc_n = 1'b1;
				end
			end
			LEX_SINGLE: begin
				if (esc_c) esc_n = 1'b0;
				else if (cls == CC_BSLASH) esc_n = 1'b1;
			end
			LEX_TRIPLE: begin
				if (esc_c) begin
					esc_n = 1'b0;
				end else if (cls == CC_BSLASH) begin
					esc_n = 1'b1;
					run_n = 2'd0;
				end else if (!is_q || run_c >= 2'd2) begin
					run_n = 2'd0;
				end else begin
					run_n = run_c + 2'd1;
				end
			end
			default: ;
		endcase
		if (code_act) begin
			priority if (!spec_c && cls == CC_HASH) begin
			end else if (!spec_c && (cls == CC_SQUOTE || cls == CC_DQUOTE)) begin
				qchar_n = (cls == CC_DQUOTE);
				run_n   = 2'd1;
				esc_n   = 1'b0;
			end else if (!spec_c && cls == CC_OPEN) begin
				if (group_c < GMAX) group_n = group_c + GW'(1);
			end else if (!spec_c && cls == CC_CLOSE) begin
				if (group_c > GMIN) group_n = group_c - GW'(1);
			end else if (cls == CC_COLON && brace_c == '0 && group_c == '0) begin
				spec_n = 1'b1;
			end else if (cls == CC_LBRACE) begin
				if (brace_c < BMAX) brace_n = brace_c + BW'(1);
			end else if (cls == CC_RBRACE) begin
				if (brace_c == '0) hit = 1'b1;
				else brace_n = brace_c - BW'(1);
			end else begin
			end
		end
	end

	assign pop       = head_valid && (!out_valid_q || res_ready);
	assign emit      = !finished_c && (hit || head_item.last);
	assign res_valid = out_valid_q;
	assign res_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brace_q     <= '0;
			group_q     <= '0;
			spec_q      <= 1'b0;
			lex_q       <= LEX_CODE;
			qchar_q     <= 1'b0;
			run_q       <= 2'd0;
			esc_q       <= 1'b0;
			cursor_q    <= '0;
			finished_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				cursor_q   <= cursor_c + INDEX_BITS'(1);
				finished_q <= finished_c || hit || head_item.last;
				brace_q    <= finished_c ? brace_c : brace_n;
				group_q    <= finished_c ? group_c : group_n;
				spec_q     <= finished_c ? spec_c : spec_n;
				lex_q      <= finished_c ? lex_c : lex_n;
				qchar_q    <= finished_c ? qchar_c : qchar_n;
				run_q      <= finished_c ? run_c : run_n;
				esc_q      <= finished_c ? esc_c : esc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_q.found    <= hit;
			out_q.position <= hit ? 16'(cursor_c) : 16'd0;
		end
	end

endmodule

// File: hw/rtl/fstring_field_end_scanner_core.sv
// Top level of the f-string field end scanner.
`timescale 1ns / 1ps
// Takes one byte of replacement-field text per cycle while byte_ready is
// high. Reports, once per scan, either the index of the closing top-level
// brace (found = 1) or, on the last byte, found = 0. A byte with first set
// restarts the scan at base_index; bytes after a result are consumed
// silently until the next first. Sustained rate is one byte per clock
// while results are taken: the scanner state updates once per byte. A byte
// passes through the byte queue and then the result register; a four-entry
// queue between the classifier and the scanner absorbs result-side stalls.
module fstring_field_end_scanner_core #(
	parameter int MAX_NEST   = 31,
	parameter int INDEX_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  fsfe_pkg::byte_item_t byte_item,
	output logic                 res_valid,
	input  logic                 res_ready,
	output fsfe_pkg::res_item_t  res_item
);
	import fsfe_pkg::*;

	logic      q_full;
	logic      q_push;
	logic      q_pop;
	logic      head_valid;
	cls_item_t push_item;
	cls_item_t head_item;

	fsfe_front u_front (
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (push_item)
	);

	fsfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	fsfe_back #(
		.MAX_NEST   (MAX_NEST),
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (q_pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item)
	);

endmodule

// File: test/field_end_checker.sv
// Checker for the f-string field end scanner: predicts each scan's result and compares it.
`timescale 1ns / 1ps
module field_end_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	input  logic                 byte_ready,
	input  fsfe_pkg::byte_item_t byte_item,
	input  logic                 res_valid,
	input  logic                 res_ready,
	input  fsfe_pkg::res_item_t  res_item,
	output int                   errors,
	output int                   awaiting
);
	import fsfe_pkg::*;

	localparam int NEST_LIMIT = 31;

	int          brace_lvl;
	int          group_lvl;
	bit          in_spec;
	lex_mode_t   lex;
	bit          dquote;
	int          quote_cnt;
	bit          esc;
	logic [15:0] next_idx;
	bit          done;
	res_item_t   pending_ends[$];
	res_item_t   want;

	task automatic clear_scan();
		brace_lvl = 0;
		group_lvl = 0;
		in_spec = 1'b0;
		lex = LEX_CODE;
		dquote = 1'b0;
		quote_cnt = 0;
		esc = 1'b0;
		next_idx = '0;
		done = 1'b0;
	endtask

	function automatic bit code_char(input logic [7:0] c);
		if (!in_spec) begin
			if (c == CHR_HASH) begin
				lex = LEX_COMMENT;
				return 1'b0;
			end
			if (c == CHR_SQUOTE || c == CHR_DQUOTE) begin
				lex = LEX_OPENING;
				dquote = (c == CHR_DQUOTE);
				quote_cnt = 1;
				esc = 1'b0;
				return 1'b0;
			end
			if (c == CHR_LPAREN || c == CHR_LBRACK) begin
				if (group_lvl < NEST_LIMIT)
					group_lvl++;
				return 1'b0;
			end
			if (c == CHR_RPAREN || c == CHR_RBRACK) begin
				if (group_lvl > -NEST_LIMIT)
					group_lvl--;
				return 1'b0;
			end
		end
		if (c == CHR_COLON && brace_lvl == 0 && group_lvl == 0) begin
			in_spec = 1'b1;
			return 1'b0;
		end
		if (c == CHR_LBRACE) begin
			if (brace_lvl < NEST_LIMIT)
				brace_lvl++;
			return 1'b0;
		end
		if (c == CHR_RBRACE) begin
			if (brace_lvl == 0)
				return 1'b1;
			brace_lvl--;
		end
		return 1'b0;
	endfunction

	function automatic bit scan_char(input logic [7:0] c);
		logic [7:0] qc;
		qc = dquote ? CHR_DQUOTE : CHR_SQUOTE;
		case (lex)
			LEX_COMMENT: begin
				if (c == CHR_LF || c == CHR_CR)
					lex = LEX_CODE;
				return 1'b0;
			end
			LEX_OPENING: begin
				if (quote_cnt >= 2) begin
					quote_cnt = 0;
					if (c == qc) begin
						lex = LEX_TRIPLE;
						esc = 1'b0;
						return 1'b0;
					end
					// two quotes then something else: empty string, byte is code
					lex = LEX_CODE;
					return code_char(c);
				end
				if (c == qc) begin
					quote_cnt = 2;
					return 1'b0;
				end
				lex = LEX_SINGLE;
				quote_cnt = 0;
				if (c == CHR_BSLASH)
					esc = 1'b1;
				return 1'b0;
			end
			LEX_SINGLE: begin
				if (esc)
					esc = 1'b0;
				else if (c == CHR_BSLASH)
					esc = 1'b1;
				else if (c == qc)
					lex = LEX_CODE;
				return 1'b0;
			end
			LEX_TRIPLE: begin
				if (esc) begin
					esc = 1'b0;
				end else if (c == CHR_BSLASH) begin
					esc = 1'b1;
					quote_cnt = 0;
				end else if (c != qc) begin
					quote_cnt = 0;
				end else if (quote_cnt >= 2) begin
					lex = LEX_CODE;
					quote_cnt = 0;
				end else begin
					quote_cnt++;
				end
				return 1'b0;
			end
			default: begin
				lex = LEX_CODE;
				return code_char(c);
			end
		endcase
	endfunction

	task automatic predict_field_end(input byte_item_t it);
		res_item_t   r;
		logic [15:0] pos;
		if (it.first) begin
			clear_scan();
			next_idx = it.base_index;
		end
		pos = next_idx;
		next_idx = next_idx + 16'd1;
		if (!done) begin
			r.found = 1'b0;
			r.position = '0;
			if (scan_char(it.ch)) begin
				r.found = 1'b1;
				r.position = pos;
			end
			if (r.found || it.last) begin
				done = 1'b1;
				pending_ends.push_back(r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			pending_ends.delete();
			errors = 0;
			awaiting = 0;
		end else begin
			if (byte_valid && byte_ready)
				predict_field_end(byte_item);
			if (res_valid && res_ready) begin
				if (pending_ends.size() == 0) begin
					$error("unexpected transaction: found=%0b position=%0d",
						res_item.found, res_item.position);
					errors++;
				end else begin
					want = pending_ends.pop_front();
					if (res_item.found !== want.found) begin
						$error("found: expected %0b, got %0b", want.found, res_item.found);
						errors++;
					end
					if (res_item.position !== want.position) begin
						$error("position: expected %0d, got %0d",
							want.position, res_item.position);
						errors++;
					end
				end
			end
			awaiting = pending_ends.size();
		end
	end

endmodule

// File: test/tb_top.sv
// Testbench top for the f-string field end scanner: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import fsfe_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_BYTES = 400;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_ready;
	byte_item_t byte_item = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	res_item_t  res_item;

	logic       byte_taken = 1'b0;
	int         errors;
	int         awaiting;
	int         quiet = 0;
	int         tx_idle_pct = 0;
	int         rx_idle_pct = 0;
	logic [7:0] field_text[$];

	always #(CLK_PERIOD / 2) clk = ~clk;

	fstring_field_end_scanner_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item (byte_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	field_end_checker ends_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item (byte_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.errors    (errors),
		.awaiting  (awaiting)
	);

	always @(posedge clk)
		byte_taken <= byte_valid && byte_ready;

	always @(negedge clk)
		res_ready <= ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin
		if ((byte_valid && byte_ready) || (res_valid && res_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic [7:0] rand_byte(input int lo, input int hi);
		return 8'($urandom_range(hi, lo));
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic f, input logic l,
		input logic [15:0] base);
		byte_item_t item;
		int         gap;
		item.ch = c;
		item.first = f;
		item.last = l;
		item.base_index = base;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= item;
		do @(negedge clk); while (!byte_taken);
	endtask

	task automatic send_field(input bit with_first, input bit with_last,
		input logic [15:0] base);
		for (int i = 0; i < field_text.size(); i++)
			send_byte(field_text[i], with_first && i == 0,
				with_last && i == field_text.size() - 1, base);
	endtask

	task automatic load_text(input string s);
		field_text.delete();
		for (int i = 0; i < s.len(); i++)
			field_text.push_back(s[i]);
	endtask

	task automatic put_string();
		logic [7:0] q;
		bit         triple;
		q = $urandom_range(1) ? CHR_DQUOTE : CHR_SQUOTE;
		triple = ($urandom_range(2) == 0);
		repeat (triple ? 3 : 1) field_text.push_back(q);
		repeat ($urandom_range(5)) begin
			case ($urandom_range(4))
				0: begin
					field_text.push_back(CHR_BSLASH);
					field_text.push_back(rand_byte(0, 255));
				end
				1: field_text.push_back(CHR_RBRACE);
				2: begin
					if (triple)
						field_text.push_back(q);
					field_text.push_back(rand_byte(8'h61, 8'h7A));
				end
				3: field_text.push_back(q == CHR_DQUOTE ? CHR_SQUOTE : CHR_HASH);
				default: field_text.push_back(rand_byte(8'h61, 8'h7A));
			endcase
		end
		repeat (triple ? 3 : 1) field_text.push_back(q);
	endtask

	task automatic put_comment();
		field_text.push_back(CHR_HASH);
		repeat ($urandom_range(4)) begin
			case ($urandom_range(3))
				0: field_text.push_back(CHR_RBRACE);
				1: field_text.push_back(CHR_SQUOTE);
				2: field_text.push_back(CHR_LBRACE);
				default: field_text.push_back(rand_byte(8'h61, 8'h7A));
			endcase
		end
		case ($urandom_range(2))
			0: field_text.push_back(CHR_CR);
			1: field_text.push_back(CHR_LF);
			default: begin
				field_text.push_back(CHR_CR);
				field_text.push_back(CHR_LF);
			end
		endcase
	endtask

	// mostly well-formed field text; closes tells whether a closing brace was appended
	task automatic build_field(output bit closes);
		int groups;
		int braces;
		int n;
		field_text.delete();
		groups = 0;
		braces = 0;
		if ($urandom_range(24) == 0) begin
			n = $urandom_range(40, 32);
			case ($urandom_range(2))
				0: begin
					repeat (n) field_text.push_back(CHR_LBRACE);
					repeat (n) field_text.push_back(CHR_RBRACE);
				end
				1: begin
					repeat (n) field_text.push_back($urandom_range(1) ? CHR_LPAREN : CHR_LBRACK);
					repeat (n) field_text.push_back($urandom_range(1) ? CHR_RPAREN : CHR_RBRACK);
				end
				default: begin
					repeat (n) field_text.push_back($urandom_range(1) ? CHR_RPAREN : CHR_RBRACK);
					repeat (n) field_text.push_back($urandom_range(1) ? CHR_LPAREN : CHR_LBRACK);
				end
			endcase
		end
		repeat ($urandom_range(8, 1)) begin
			case ($urandom_range(10))
				0, 1, 2: field_text.push_back(rand_byte(8'h61, 8'h7A));
				3: begin
					field_text.push_back($urandom_range(1) ? CHR_LPAREN : CHR_LBRACK);
					groups++;
				end
				4: begin
					if (groups > 0) begin
						field_text.push_back($urandom_range(1) ? CHR_RPAREN : CHR_RBRACK);
						groups--;
					end else begin
						field_text.push_back(rand_byte(8'h30, 8'h39));
					end
				end
				5: begin
					field_text.push_back(CHR_LBRACE);
					braces++;
				end
				6: begin
					if (braces > 0) begin
						field_text.push_back(CHR_RBRACE);
						braces--;
					end else begin
						field_text.push_back(rand_byte(8'h41, 8'h5A));
					end
				end
				7: put_string();
				8: put_comment();
				9: begin
					field_text.push_back(CHR_COLON);
					repeat ($urandom_range(4)) begin
						case ($urandom_range(4))
							0: field_text.push_back(CHR_HASH);
							1: field_text.push_back(CHR_DQUOTE);
							2: field_text.push_back(CHR_LPAREN);
							3: field_text.push_back(CHR_RBRACK);
							default: field_text.push_back(rand_byte(8'h61, 8'h7A));
						endcase
					end
				end
				default: field_text.push_back(rand_byte(0, 255));
			endcase
		end
		repeat (braces) field_text.push_back(CHR_RBRACE);
		repeat (groups) field_text.push_back(CHR_RPAREN);
		closes = ($urandom_range(99) < 85);
		if (closes)
			field_text.push_back(CHR_RBRACE);
	endtask

	initial begin
		bit          closes;
		bit          trail;
		int          broken;
		int          scan_bytes;
		logic [15:0] base;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		tx_idle_pct = 6;
		rx_idle_pct = 73;

		// no first after reset: scan starts at index 0
		field_text = '{8'h00, CHR_RBRACE};
		send_field(1'b0, 1'b0, 16'h0000);
		// scan already reported, byte ignored
		send_byte(8'hFF, 1'b0, 1'b1, 16'h0000);
		// hit on the last byte, index wraps
		load_text("x}");
		send_field(1'b1, 1'b1, 16'hFFFF);
		// empty string, then the brace is code
		load_text("''}");
		send_field(1'b1, 1'b0, 16'h0100);
		// comments ended by CR LF and by LF
		field_text = '{CHR_HASH, CHR_RBRACE, CHR_CR, CHR_LF, CHR_HASH, CHR_LF, CHR_RBRACE};
		send_field(1'b1, 1'b0, 16'h7FFF);
		// unterminated triple-quoted string
		load_text("'''a}");
		send_field(1'b1, 1'b1, 16'h8000);
		// hash is plain text in the format spec
		load_text("a:#}");
		send_field(1'b1, 1'b1, 16'h5555);

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 73 : 0;
			rx_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 6 : 0;
			scan_bytes = 0;
			while (scan_bytes < PHASE_BYTES) begin
				if ($urandom_range(9) == 0) begin
					repeat ($urandom_range(4, 1))
						send_byte(rand_byte(0, 255), $urandom_range(3) == 0,
							$urandom_range(3) == 0, 16'($urandom_range(16'hFFFF)));
				end else begin
					build_field(closes);
					base = ($urandom_range(9) == 0) ? 16'hFFFF - 16'($urandom_range(5))
						: 16'($urandom_range(16'hFFFF));
					broken = $urandom_range(19);
					trail = closes && $urandom_range(4) == 0;
					send_field(broken != 1, !trail && broken != 0, base);
					scan_bytes += field_text.size();
					if (trail) begin
						n_trail_loop: for (int k = $urandom_range(3, 1); k > 0; k--)
							send_byte(rand_byte(0, 255), 1'b0, k == 1, base);
					end
				end
			end
		end
		byte_valid <= 1'b0;

		while (awaiting != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
